/* hdl/eoe_pkg.sv */
// eoe_pkg: shared types and constants for the EoE fragment reassembler.
// No dependencies; imported by every module under hdl/.
package eoe_pkg;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_DONE     = 2'd1,
		ST_BAD_DATA = 2'd2,
		ST_BAD_MBX  = 2'd3
	} status_t;

	localparam logic [3:0]  EOE_MBX_TYPE = 4'd2;
	localparam logic [15:0] HDR_BYTES    = 16'd4;
	localparam logic [15:0] STAMP_BYTES  = 16'd4;
	localparam logic [15:0] CAP_RESET    = 16'd1536;

	// APB map: buffer_capacity at byte address 0
	localparam int unsigned ADDR_W  = 3;
	localparam logic        REG_CAP = 1'b0;   // word index, paddr[2]

	typedef struct packed {
		logic [3:0]  mailbox_type;
		logic [15:0] mailbox_length;
		logic [5:0]  fragment_number;
		logic [3:0]  frame_number;
		logic [5:0]  offset_blocks;
		logic        last_fragment;
		logic        time_appended;
	} hdr_t;

	typedef struct packed {
		status_t     status;
		logic        copy_enable;
		logic [15:0] copy_offset;
		logic [15:0] copy_length;
		logic [15:0] frame_length;
	} result_t;

endpackage

/* hdl/eoe_fragment_reassembler_top.sv */
// eoe_fragment_reassembler_top: EoE fragment header checker, top level.
// Depends on eoe_pkg, eoe_apb_regs, eoe_frag_core.
//
//  channel | direction | handshake            | beat contents
//  --------+-----------+----------------------+---------------------------------------
//  in      | sink      | in_valid / in_stall  | one mailbox header (7 fields)
//  out     | source    | out_valid / out_stall| status, copy enable/offset/length, length
//  cfg     | APB slave | psel/penable/pready  | buffer_capacity at address 0
//
// An accepted header is held in the header register (_s1), then in the result register (_s2),
// which drives out_valid; one beat per cycle sustained while out_stall is low.
// The header register (_s1) feeds the decision logic and frame state; the result
// register (_s2) parts the two sides, so a new header is taken while a result waits.
// in_stall rises only when both registers are full and out_stall is high.
// Reset clears valid flags and frame state; buffer_capacity resets to 1536.
module eoe_fragment_reassembler_top import eoe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input header channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        mailbox_type,
	input  logic [15:0]       mailbox_length,
	input  logic [5:0]        fragment_number,
	input  logic [3:0]        frame_number,
	input  logic [5:0]        offset_blocks,
	input  logic              last_fragment,
	input  logic              time_appended,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic              copy_enable,
	output logic [15:0]       copy_offset,
	output logic [15:0]       copy_length,
	output logic [15:0]       frame_length,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	hdr_t        hdr_s1;
	logic        valid_s1;
	result_t     res_s2;
	logic        valid_s2;
	result_t     res_c;
	logic [15:0] cap;
	logic        adv;
	logic        take_in;

	// header moves on when the result register is free or being drained
	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign take_in  = in_valid & ~in_stall;

	eoe_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.buffer_capacity (cap)
	);

	eoe_frag_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (adv),
		.hdr             (hdr_s1),
		.buffer_capacity (cap),
		.res             (res_c)
	);

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && !out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			hdr_s1.mailbox_type    <= mailbox_type;
			hdr_s1.mailbox_length  <= mailbox_length;
			hdr_s1.fragment_number <= fragment_number;
			hdr_s1.frame_number    <= frame_number;
			hdr_s1.offset_blocks   <= offset_blocks;
			hdr_s1.last_fragment   <= last_fragment;
			hdr_s1.time_appended   <= time_appended;
		end
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = res_s2.status;
	assign copy_enable  = res_s2.copy_enable;
	assign copy_offset  = res_s2.copy_offset;
	assign copy_length  = res_s2.copy_length;
	assign frame_length = res_s2.frame_length;

	// input is only held off when a finished result is backed up
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall))
		else $error("input stalled with result register free");

	// error results never carry a copy
	a_err_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.status == ST_BAD_DATA || res_s2.status == ST_BAD_MBX))
		|-> !res_s2.copy_enable)
		else $error("copy requested on an error result");

	// frame length only reported with a completed frame
	a_len_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.frame_length != 16'd0) |-> (res_s2.status == ST_DONE))
		else $error("frame length without frame complete");

	// copy fields are zero when nothing is stored
	a_copy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.copy_enable)
		|-> (res_s2.copy_offset == 16'd0 && res_s2.copy_length == 16'd0))
		else $error("copy fields set without copy enable");

endmodule

/* hdl/eoe_apb_regs.sv */
// eoe_apb_regs: APB register slice holding buffer_capacity.
// Depends on eoe_pkg.
module eoe_apb_regs import eoe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [15:0]       buffer_capacity
);

	logic [15:0] cap_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_en && paddr[2] == REG_CAP) begin
			cap_q <= pwdata[15:0];
		end
	end

	// other addresses read as zero
	assign prdata          = (paddr[2] == REG_CAP) ? {16'd0, cap_q} : 32'd0;
	assign buffer_capacity = cap_q;

endmodule

/* hdl/eoe_frag_core.sv */
// eoe_frag_core: frame tracking state and per-header decision logic.
// Depends on eoe_pkg; state advances when the top level moves a beat on.
module eoe_frag_core import eoe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  hdr_t        hdr,
	input  logic [15:0] buffer_capacity,
	output result_t     res
);

	logic [7:0]  exp_frag_q, exp_frag_n, e_exp;
	logic [10:0] frame_size_q, frame_size_n, e_size;
	logic [15:0] write_off_q, write_off_n, e_off;
	logic [3:0]  frame_id_q, frame_id_n, e_id;
	logic [15:0] payload;
	logic [16:0] end_sum;
	logic        mismatch;
	logic        go;
	logic        fits;

	always_comb begin
		res          = '0;
		res.status   = ST_BUSY;
		exp_frag_n   = exp_frag_q;
		frame_size_n = frame_size_q;
		write_off_n  = write_off_q;
		frame_id_n   = frame_id_q;
		e_exp        = exp_frag_q;
		e_size       = frame_size_q;
		e_off        = write_off_q;
		e_id         = frame_id_q;
		payload      = hdr.mailbox_length - HDR_BYTES;
		mismatch     = exp_frag_q != {2'b00, hdr.fragment_number};
		go           = 1'b0;
		end_sum      = '0;
		fits         = 1'b0;

		if (hdr.mailbox_type != EOE_MBX_TYPE) begin
			res.status = ST_BAD_MBX;
		end else begin
			// out-of-order fragment drops a frame in progress
			if (mismatch && exp_frag_q != 8'd0) begin
				e_exp  = '0;
				e_size = '0;
				e_off  = '0;
				e_id   = '0;
			end
			if (mismatch && hdr.fragment_number != 6'd0) begin
				res.status   = ST_BAD_DATA;
				exp_frag_n   = e_exp;
				frame_size_n = e_size;
				write_off_n  = e_off;
				frame_id_n   = e_id;
			end else if (e_exp == 8'd0) begin
				// first fragment: offset field is the frame size in blocks
				e_size = {hdr.offset_blocks, 5'b0};
				e_off  = '0;
				e_id   = hdr.frame_number;
				go     = 1'b1;
			end else if (e_id != hdr.frame_number ||
					e_off != {5'b0, hdr.offset_blocks, 5'b0}) begin
				res.status   = ST_BAD_DATA;
				exp_frag_n   = '0;
				frame_size_n = '0;
				write_off_n  = '0;
				frame_id_n   = '0;
			end else begin
				go = 1'b1;
			end

			if (go) begin
				end_sum = {1'b0, e_off} + {1'b0, payload};
				fits    = (end_sum <= {6'b0, e_size}) && (end_sum <= {1'b0, buffer_capacity});
				if (fits) begin
					res.copy_enable = 1'b1;
					res.copy_offset = e_off;
					res.copy_length = payload;
					e_off           = end_sum[15:0];
					e_exp           = e_exp + 8'd1;
				end
				if (hdr.last_fragment) begin
					res.status       = ST_DONE;
					res.frame_length = hdr.time_appended ? (e_off - STAMP_BYTES) : e_off;
					exp_frag_n       = '0;
					frame_size_n     = '0;
					write_off_n      = '0;
					frame_id_n       = '0;
				end else begin
					exp_frag_n   = e_exp;
					frame_size_n = e_size;
					write_off_n  = e_off;
					frame_id_n   = e_id;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_frag_q   <= '0;
			frame_size_q <= '0;
			write_off_q  <= '0;
			frame_id_q   <= '0;
		end else if (advance) begin
			exp_frag_q   <= exp_frag_n;
			frame_size_q <= frame_size_n;
			write_off_q  <= write_off_n;
			frame_id_q   <= frame_id_n;
		end
	end

endmodule
